FILE: design/frustum_sphere_box_cull_macros.svh
// assertion macros shared by the frustum cull modules
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef FRUSTUM_SPHERE_BOX_CULL_MACROS_SVH
`define FRUSTUM_SPHERE_BOX_CULL_MACROS_SVH

// checked only outside reset
`define FSBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define FSBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/fsbc_pkg.sv
// shared constants, types and widths for the frustum cull block
// no dependencies
`default_nettype none

package fsbc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 14;

  localparam int NUM_PLANES  = 6;
  localparam int FULL_COUNT  = 8;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int PLANE_W     = 64;
  localparam int COEF_W      = 16;
  localparam int NUM_AXES    = 3;
  localparam int RADIUS_W    = COORD_WIDTH - 1;

  // exact distance width: three products summed, plus scaled offset, against scaled radius
  localparam int PROD_W = COEF_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int OFS_W  = COEF_W + FRAC_BITS;
  localparam int RAD_W  = RADIUS_W + FRAC_BITS;
  localparam int W1     = (SUM_W > OFS_W) ? SUM_W : OFS_W;
  localparam int W2     = (W1 > RAD_W) ? W1 : RAD_W;
  localparam int DIST_W = W2 + 2;

  typedef enum logic {
    CMD_SPHERE = 1'b0,
    CMD_CORNER = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CONT_OUTSIDE = 2'd0,
    CONT_PARTIAL = 2'd1,
    CONT_INSIDE  = 2'd2
  } cont_t;

  typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_set_t;
  typedef logic [PROD_W-1:0] prod_t;

  // item after the input register
  typedef struct packed {
    cmd_t                                 command;
    logic                                 last_corner;
    logic [RADIUS_W-1:0]                  radius;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] point;
  } in_item_t;

  // item after the product register
  typedef struct packed {
    cmd_t                                 command;
    logic                                 last_corner;
    logic [RADIUS_W-1:0]                  radius;
    prod_t [NUM_PLANES-1:0][NUM_AXES-1:0] prod;
  } prod_item_t;

endpackage

`default_nettype wire

FILE: design/fsbc_mul.sv
// product stage: the eighteen normal-times-coordinate products, registered
// depends on fsbc_pkg
`default_nettype none

module fsbc_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fsbc_pkg::plane_set_t  planes,
  input  wire logic                  s1_valid,
  input  wire fsbc_pkg::in_item_t    s1_item,
  output logic                       s1_ready,
  output logic                       s2_valid,
  output fsbc_pkg::prod_item_t       s2_item,
  input  wire logic                  s2_ready
);

  logic                  s2_valid_r;
  logic                  s2_valid_nxt;
  fsbc_pkg::prod_item_t  s2_item_r;
  fsbc_pkg::prod_item_t  s2_item_nxt;
  logic                  load;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  always_comb begin
    logic signed [fsbc_pkg::PROD_W-1:0] coef;
    logic signed [fsbc_pkg::PROD_W-1:0] coord;
    s2_item_nxt.command     = s1_item.command;
    s2_item_nxt.last_corner = s1_item.last_corner;
    s2_item_nxt.radius      = s1_item.radius;
    for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
      for (int j = 0; j < fsbc_pkg::NUM_AXES; j++) begin
        coef  = fsbc_pkg::PROD_W'($signed(planes[k][fsbc_pkg::COEF_W*j +: fsbc_pkg::COEF_W]));
        coord = fsbc_pkg::PROD_W'($signed(s1_item.point[j]));
        s2_item_nxt.prod[k][j] = fsbc_pkg::prod_t'(coef * coord);
      end
    end
  end

  always_comb begin
    if (load) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_item  = s2_item_r;

endmodule

`default_nettype wire

FILE: design/fsbc_judge.sv
// judge stage: plane distances, sphere test, corner counters and result register
// depends on fsbc_pkg and frustum_sphere_box_cull_macros.svh
`default_nettype none
`include "frustum_sphere_box_cull_macros.svh"

module fsbc_judge (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fsbc_pkg::plane_set_t  planes,
  input  wire logic                  s2_valid,
  input  wire fsbc_pkg::prod_item_t  s2_item,
  output logic                       s2_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output fsbc_pkg::cont_t            out_cont
);

  logic [fsbc_pkg::NUM_PLANES-1:0][fsbc_pkg::CNT_W-1:0] cnt_r;
  logic [fsbc_pkg::NUM_PLANES-1:0][fsbc_pkg::CNT_W-1:0] cnt_nxt;
  logic                                               out_valid_r;
  logic                                               out_valid_nxt;
  fsbc_pkg::cont_t                                    out_cont_r;
  fsbc_pkg::cont_t                                    cont_nxt;
  logic                                               s2_fire;
  logic                                               makes_result;
  logic                                               is_corner;

  assign s2_ready     = !out_valid_r || out_ready;
  assign s2_fire      = s2_valid && s2_ready;
  assign is_corner    = (s2_item.command == fsbc_pkg::CMD_CORNER);
  assign makes_result = !is_corner || s2_item.last_corner;

  always_comb begin
    logic signed [fsbc_pkg::DIST_W-1:0]                 pdist;
    logic signed [fsbc_pkg::DIST_W-1:0]                 rad_s;
    logic                                               any_out;
    logic                                               all_in;
    logic                                               any_zero;
    logic                                               all_full;
    logic [fsbc_pkg::NUM_PLANES-1:0][fsbc_pkg::CNT_W-1:0] upd;
    rad_s    = $signed(fsbc_pkg::DIST_W'(s2_item.radius)) <<< fsbc_pkg::FRAC_BITS;
    any_out  = 1'b0;
    all_in   = 1'b1;
    any_zero = 1'b0;
    all_full = 1'b1;
    upd      = cnt_r;
    for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
      pdist = $signed(fsbc_pkg::DIST_W'($signed(
                planes[k][fsbc_pkg::COEF_W*fsbc_pkg::NUM_AXES +: fsbc_pkg::COEF_W])))
              <<< fsbc_pkg::FRAC_BITS;
      for (int j = 0; j < fsbc_pkg::NUM_AXES; j++) begin
        pdist = pdist + fsbc_pkg::DIST_W'($signed(s2_item.prod[k][j]));
      end
      if (pdist <= -rad_s) begin
        any_out = 1'b1;
      end
      if (!(pdist > rad_s)) begin
        all_in = 1'b0;
      end
      // positive side counts up, saturating at a full box
      if (pdist > 0 && cnt_r[k] < fsbc_pkg::CNT_W'(fsbc_pkg::FULL_COUNT)) begin
        upd[k] = cnt_r[k] + fsbc_pkg::CNT_W'(1);
      end
      if (upd[k] == '0) begin
        any_zero = 1'b1;
      end
      if (upd[k] != fsbc_pkg::CNT_W'(fsbc_pkg::FULL_COUNT)) begin
        all_full = 1'b0;
      end
    end

    if (!is_corner) begin
      if (any_out) begin
        cont_nxt = fsbc_pkg::CONT_OUTSIDE;
      end else if (all_in) begin
        cont_nxt = fsbc_pkg::CONT_INSIDE;
      end else begin
        cont_nxt = fsbc_pkg::CONT_PARTIAL;
      end
    end else begin
      if (any_zero) begin
        cont_nxt = fsbc_pkg::CONT_OUTSIDE;
      end else if (all_full) begin
        cont_nxt = fsbc_pkg::CONT_INSIDE;
      end else begin
        cont_nxt = fsbc_pkg::CONT_PARTIAL;
      end
    end

    cnt_nxt = cnt_r;
    if (s2_fire && is_corner) begin
      cnt_nxt = s2_item.last_corner ? '0 : upd;
    end

    if (s2_fire && makes_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && makes_result) begin
      out_cont_r <= cont_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cont  = out_cont_r;

  logic cnt_in_range;
  always_comb begin
    cnt_in_range = 1'b1;
    for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
      if (cnt_r[k] > fsbc_pkg::CNT_W'(fsbc_pkg::FULL_COUNT)) begin
        cnt_in_range = 1'b0;
      end
    end
  end

  `FSBC_ASSERT_ALWAYS(a_cnt_saturates, cnt_in_range, "corner count above full")
  `FSBC_ASSERT(a_last_clears, (s2_fire && is_corner && s2_item.last_corner) |=> (cnt_r == '0),
    "counts not cleared after last corner")
  `FSBC_ASSERT(a_sphere_keeps_counts, (s2_fire && !is_corner) |=> $stable(cnt_r),
    "sphere disturbed corner counts")
  `FSBC_ASSERT(a_corner_no_result, (s2_fire && !makes_result && out_valid_r && !out_ready)
    |=> (out_valid_r && $stable(out_cont_r)), "mid-box corner touched a held result")

endmodule

`default_nettype wire

FILE: design/frustum_sphere_box_cull.sv
// frustum_sphere_box_cull: top level, config registers, input register and stage wiring
// depends on fsbc_pkg, fsbc_mul and fsbc_judge
//
// Classifies a sphere, or a box given as a stream of corners, against six planes.
// Config: cfg_index 0..5 picks right, left, bottom, top, far, near; cfg_data packs
//   nx, ny, nz (signed Q1.14) in bits 47:0 and the signed offset in 63:48.
//   cfg_ready is always high; indexes 6 and 7 are dropped.
// Input: one item per transfer. command 0 is a sphere (point plus radius), command 1
//   is one box corner; in_last_corner closes the box.
// Output: out_containment 0 outside, 1 partial, 2 inside. Every sphere gives one
//   result, a box gives one at its last corner, other corners give none.
// Pipeline: input register, product register, result register, in that order between
//   the input transfer and out_valid. Throughput one item per cycle while out_ready
//   stays high; the eighteen multipliers in the product stage set the cycle.
// Reset clears the plane registers, the per-plane corner counts and all valid flags.
// When the receiver stalls, the result holds and the stages behind it fill; in_ready
//   drops once the input register, product register and result register are all full.
`default_nettype none

module frustum_sphere_box_cull (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic                                     in_command,
  input  wire logic signed [fsbc_pkg::COORD_WIDTH-1:0]  in_point_x,
  input  wire logic signed [fsbc_pkg::COORD_WIDTH-1:0]  in_point_y,
  input  wire logic signed [fsbc_pkg::COORD_WIDTH-1:0]  in_point_z,
  input  wire logic [fsbc_pkg::RADIUS_W-1:0]            in_radius,
  input  wire logic                                     in_last_corner,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic [1:0]                                    out_containment,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [fsbc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [fsbc_pkg::PLANE_W-1:0]             cfg_data
);

  fsbc_pkg::plane_set_t  plane_r;
  fsbc_pkg::plane_set_t  plane_nxt;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  fsbc_pkg::in_item_t    s1_item_r;
  fsbc_pkg::in_item_t    s1_item_nxt;
  logic                  s1_ready;
  logic                  s2_valid;
  logic                  s2_ready;
  fsbc_pkg::prod_item_t  s2_item;
  fsbc_pkg::cont_t       out_cont;
  logic                  in_fire;

  assign cfg_ready = 1'b1;

  always_comb begin
    plane_nxt = plane_r;
    for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
      if (cfg_valid && cfg_index == fsbc_pkg::CFG_IDX_W'(k)) begin
        plane_nxt[k] = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else begin
      plane_r <= plane_nxt;
    end
  end

  // input register
  assign in_ready = !s1_valid_r || s1_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_item_nxt.command     = fsbc_pkg::cmd_t'(in_command);
    s1_item_nxt.last_corner = in_last_corner;
    s1_item_nxt.radius      = in_radius;
    s1_item_nxt.point[0]    = in_point_x;
    s1_item_nxt.point[1]    = in_point_y;
    s1_item_nxt.point[2]    = in_point_z;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  fsbc_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .planes   (plane_r),
    .s1_valid (s1_valid_r),
    .s1_item  (s1_item_r),
    .s1_ready (s1_ready),
    .s2_valid (s2_valid),
    .s2_item  (s2_item),
    .s2_ready (s2_ready)
  );

  fsbc_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .planes    (plane_r),
    .s2_valid  (s2_valid),
    .s2_item   (s2_item),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cont  (out_cont)
  );

  assign out_containment = out_cont;

endmodule

`default_nettype wire

FILE: test/frustum_sphere_box_cull_tb.sv
// testbench for frustum_sphere_box_cull: directed and random spheres and box corners
// against several plane settings, with idle and stall phases on both channels
// depends on fsbc_pkg and the frustum_sphere_box_cull rtl
`timescale 1ns / 100ps

module frustum_sphere_box_cull_tb;

  localparam int  DRAIN_CYCLES       = 8;
  localparam int  RANDOM_PER_SETTING = 110;
  localparam int  HOLD_OFF_CYCLES    = 300;
  localparam int  UNIT_COEF          = 1 << fsbc_pkg::FRAC_BITS;
  localparam time TIMEOUT_NS         = 2000000;

  typedef logic [fsbc_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic signed [fsbc_pkg::COORD_WIDTH-1:0] coord_t;
  typedef logic [fsbc_pkg::RADIUS_W-1:0] rad_t;

  typedef enum logic [fsbc_pkg::CFG_IDX_W-1:0] {
    REG_PLANE_RIGHT  = 3'd0,
    REG_PLANE_LEFT   = 3'd1,
    REG_PLANE_BOTTOM = 3'd2,
    REG_PLANE_TOP    = 3'd3,
    REG_PLANE_FAR    = 3'd4,
    REG_PLANE_NEAR   = 3'd5
  } plane_reg_e;

  typedef enum int {
    MODE_CUBE,
    MODE_TILTED,
    MODE_RANDOM,
    MODE_EXTREME
  } plane_mode_e;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic                               in_command;
  coord_t                             in_point_x;
  coord_t                             in_point_y;
  coord_t                             in_point_z;
  rad_t                               in_radius;
  logic                               in_last_corner;
  logic                               out_valid;
  logic                               out_ready;
  logic [1:0]                         out_containment;
  logic                               cfg_valid;
  logic                               cfg_ready;
  cfg_idx_t                           cfg_index;
  logic [fsbc_pkg::PLANE_W-1:0]       cfg_data;

  // predictor state
  logic [fsbc_pkg::PLANE_W-1:0] plane_coef [fsbc_pkg::NUM_PLANES];
  logic [fsbc_pkg::CNT_W-1:0]   corner_tally [fsbc_pkg::NUM_PLANES];
  fsbc_pkg::cont_t              expected_cont_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int world_scale;
  int err_count;
  int n_spheres, n_corners, n_boxes, n_settings;
  int n_outside, n_partial, n_inside;
  fsbc_pkg::cont_t want;

  frustum_sphere_box_cull DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_radius       (in_radius),
    .in_last_corner  (in_last_corner),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_containment (out_containment),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic longint plane_distance(input logic [fsbc_pkg::PLANE_W-1:0] p,
                                            input coord_t x, input coord_t y,
                                            input coord_t z);
    logic signed [fsbc_pkg::COEF_W-1:0] nx, ny, nz, d;
    nx = p[fsbc_pkg::COEF_W-1:0];
    ny = p[2*fsbc_pkg::COEF_W-1:fsbc_pkg::COEF_W];
    nz = p[3*fsbc_pkg::COEF_W-1:2*fsbc_pkg::COEF_W];
    d  = p[4*fsbc_pkg::COEF_W-1:3*fsbc_pkg::COEF_W];
    return longint'(nx) * longint'(x) + longint'(ny) * longint'(y) +
           longint'(nz) * longint'(z) + (longint'(d) <<< fsbc_pkg::FRAC_BITS);
  endfunction

  function automatic fsbc_pkg::cont_t classify(input bit outside, input int hits);
    if (outside) return fsbc_pkg::CONT_OUTSIDE;
    if (hits == fsbc_pkg::NUM_PLANES) return fsbc_pkg::CONT_INSIDE;
    return fsbc_pkg::CONT_PARTIAL;
  endfunction

  task automatic predict_containment(input fsbc_pkg::cmd_t cmd, input coord_t x,
                                     input coord_t y, input coord_t z, input rad_t r,
                                     input logic is_last);
    longint dist_v, rad;
    bit     outside;
    int     hits;
    if (cmd == fsbc_pkg::CMD_SPHERE) begin
      n_spheres++;
      rad = longint'(r) <<< fsbc_pkg::FRAC_BITS;
      outside = 1'b0;
      hits = 0;
      for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
        dist_v = plane_distance(plane_coef[k], x, y, z);
        if (dist_v <= -rad) outside = 1'b1;
        if (dist_v > rad) hits++;
      end
      expected_cont_q.push_back(classify(outside, hits));
    end else begin
      n_corners++;
      for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
        if (plane_distance(plane_coef[k], x, y, z) > 0 &&
            corner_tally[k] < fsbc_pkg::FULL_COUNT)
          corner_tally[k]++;
      end
      if (is_last) begin
        n_boxes++;
        outside = 1'b0;
        hits = 0;
        for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
          if (corner_tally[k] == 0) outside = 1'b1;
          if (corner_tally[k] == fsbc_pkg::FULL_COUNT) hits++;
          corner_tally[k] = '0;
        end
        expected_cont_q.push_back(classify(outside, hits));
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_cont_q.size() == 0) begin
        report_mismatch($sformatf("containment %0d with nothing expected", out_containment));
      end else begin
        want = expected_cont_q.pop_front();
        if (out_containment !== want)
          report_mismatch($sformatf("containment %0d, expected %0d", out_containment, want));
        case (want)
          fsbc_pkg::CONT_OUTSIDE: n_outside++;
          fsbc_pkg::CONT_PARTIAL: n_partial++;
          default:                n_inside++;
        endcase
      end
    end
  end

  // receiver: random stalls, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("frustum_sphere_box_cull test failed");
    $finish;
  end

  function automatic coord_t clamp_coord(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[fsbc_pkg::COORD_WIDTH-1:0];
  endfunction

  function automatic int rand_signed(input int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic logic [fsbc_pkg::PLANE_W-1:0] pack_plane(input int nx, input int ny,
                                                              input int nz, input int d);
    logic [fsbc_pkg::COEF_W-1:0] fx, fy, fz, fd;
    fx = nx[fsbc_pkg::COEF_W-1:0];
    fy = ny[fsbc_pkg::COEF_W-1:0];
    fz = nz[fsbc_pkg::COEF_W-1:0];
    fd = d[fsbc_pkg::COEF_W-1:0];
    return {fd, fz, fy, fx};
  endfunction

  // right, top and far planes face toward negative coordinates
  function automatic int inward_sign(input int k);
    if (k == REG_PLANE_RIGHT || k == REG_PLANE_TOP || k == REG_PLANE_FAR) return -1;
    return 1;
  endfunction

  function automatic int extreme_value();
    case ($urandom_range(3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return rand_signed(32767);
    endcase
  endfunction

  task automatic send_item(input fsbc_pkg::cmd_t cmd, input coord_t x, input coord_t y,
                           input coord_t z, input rad_t r, input logic is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_command     = cmd;
    in_point_x     = x;
    in_point_y     = y;
    in_point_z     = z;
    in_radius      = r;
    in_last_corner = is_last;
    do @(posedge clk); while (!in_ready);
    predict_containment(cmd, x, y, z, r, is_last);
  endtask

  task automatic send_sphere(input int x, input int y, input int z, input int r);
    send_item(fsbc_pkg::CMD_SPHERE, clamp_coord(x), clamp_coord(y), clamp_coord(z),
              r[fsbc_pkg::RADIUS_W-1:0], 1'($urandom_range(1)));
  endtask

  // corners walk the eight sign combinations of the half extents
  task automatic send_box(input int cx, input int cy, input int cz, input int hx,
                          input int hy, input int hz, input int n, input bit close);
    for (int c = 0; c < n; c++) begin
      send_item(fsbc_pkg::CMD_CORNER,
                clamp_coord(cx + ((c & 1) ? hx : -hx)),
                clamp_coord(cy + ((c & 2) ? hy : -hy)),
                clamp_coord(cz + ((c & 4) ? hz : -hz)),
                fsbc_pkg::RADIUS_W'($urandom), close && (c == n - 1));
    end
  endtask

  task automatic send_raw(input fsbc_pkg::cmd_t cmd);
    send_item(cmd, fsbc_pkg::COORD_WIDTH'($urandom), fsbc_pkg::COORD_WIDTH'($urandom),
              fsbc_pkg::COORD_WIDTH'($urandom), fsbc_pkg::RADIUS_W'($urandom),
              1'($urandom));
  endtask

  task automatic write_plane(input cfg_idx_t idx, input logic [fsbc_pkg::PLANE_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < fsbc_pkg::NUM_PLANES) plane_coef[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // corners give no result, so allow the pipeline to empty after the last one
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cont_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_planes(input plane_mode_e mode, input int half_size);
    logic [fsbc_pkg::PLANE_W-1:0] val;
    int n [fsbc_pkg::NUM_AXES];
    int d;
    world_scale = (mode == MODE_RANDOM || mode == MODE_EXTREME) ? 32767 : half_size;
    n_settings++;
    for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
      case (mode)
        MODE_CUBE: begin
          for (int a = 0; a < fsbc_pkg::NUM_AXES; a++) n[a] = 0;
          n[k / 2] = inward_sign(k) * UNIT_COEF;
          val = pack_plane(n[0], n[1], n[2], half_size);
        end
        MODE_TILTED: begin
          for (int a = 0; a < fsbc_pkg::NUM_AXES; a++) n[a] = rand_signed(4000);
          n[k / 2] = inward_sign(k) * (UNIT_COEF - int'($urandom_range(4000)));
          d = half_size + rand_signed(half_size / 4);
          val = pack_plane(n[0], n[1], n[2], d);
        end
        MODE_RANDOM: val = {$urandom, $urandom};
        default: val = pack_plane(extreme_value(), extreme_value(), extreme_value(),
                                  extreme_value());
      endcase
      write_plane(cfg_idx_t'(k), val);
    end
  endtask

  task automatic run_random(input int n_items);
    int start, pick, s, corners, rmax;
    start = n_spheres + n_corners;
    while (n_spheres + n_corners - start < n_items) begin
      pick = int'($urandom_range(99));
      s = world_scale;
      if (pick < 55) begin
        corners = ($urandom_range(9) < 7) ? 8 : int'($urandom_range(1, 12));
        send_box(rand_signed(2 * s), rand_signed(2 * s), rand_signed(2 * s),
                 int'($urandom_range(s)), int'($urandom_range(s)), int'($urandom_range(s)),
                 corners, 1'b1);
      end else if (pick < 85) begin
        rmax = (s > 16383) ? 32767 : 2 * s;
        send_sphere(rand_signed(2 * s), rand_signed(2 * s), rand_signed(2 * s),
                    ($urandom_range(9) == 0) ? 32767 : int'($urandom_range(rmax)));
      end else if (pick < 95) begin
        send_raw(fsbc_pkg::CMD_SPHERE);
      end else begin
        send_raw(fsbc_pkg::CMD_CORNER);
      end
    end
  endtask

  task automatic test_reset_state();
    // all planes zero: every distance is zero
    send_sphere(0, 0, 0, 0);
    send_sphere(100, -100, 7, 5);
    send_item(fsbc_pkg::CMD_CORNER, 16'sd10, 16'sd20, 16'sd30, '0, 1'b1);
  endtask

  task automatic test_directed();
    wait_idle();
    load_planes(MODE_CUBE, 1000);
    // writes beyond the last plane are dropped
    write_plane(cfg_idx_t'(fsbc_pkg::NUM_PLANES), {$urandom, $urandom});
    write_plane(cfg_idx_t'(fsbc_pkg::NUM_PLANES + 1), {$urandom, $urandom});
    send_sphere(0, 0, 0, 10);
    send_sphere(0, 0, 0, 32767);
    send_sphere(32767, -32768, 0, 0);
    send_sphere(-32768, 32767, -32768, 32767);
    send_sphere(999, 0, 0, 0);
    send_sphere(1000, 0, 0, 0);
    send_sphere(1010, 0, 0, 10);
    // nine corners inside, sphere in the middle, counts saturate
    send_box(0, 0, 0, 500, 500, 500, 4, 1'b0);
    send_sphere(0, 0, 0, 2000);
    send_box(0, 0, 0, 500, 500, 500, 5, 1'b1);
    // lone last corner
    send_item(fsbc_pkg::CMD_CORNER, 16'sd0, 16'sd0, 16'sd0, '1, 1'b1);
    send_box(0, 0, 0, 1500, 0, 0, 2, 1'b1);
    send_box(3000, 0, 0, 100, 100, 100, 2, 1'b1);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int s = 0; s < 3; s++) begin
        wait_idle();
        case (s)
          0:       load_planes(MODE_CUBE, int'($urandom_range(16, 12000)));
          1:       load_planes(MODE_TILTED, int'($urandom_range(16, 12000)));
          default: load_planes((ph % 2 == 0) ? MODE_RANDOM : MODE_EXTREME, 0);
        endcase
        run_random(RANDOM_PER_SETTING);
      end
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    load_planes(MODE_CUBE, 2000);
    @(posedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    run_random(40);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = fsbc_pkg::CMD_SPHERE;
    in_point_x     = '0;
    in_point_y     = '0;
    in_point_z     = '0;
    in_radius      = '0;
    in_last_corner = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    world_scale    = 1000;
    err_count      = 0;
    for (int k = 0; k < fsbc_pkg::NUM_PLANES; k++) begin
      plane_coef[k]   = '0;
      corner_tally[k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_directed();
    test_random_phases();
    test_backpressure();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (expected_cont_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_cont_q.size()));

    $display("covered %0d spheres and %0d box corners (%0d boxes) over %0d plane settings",
             n_spheres, n_corners, n_boxes, n_settings);
    $display("results checked: %0d outside, %0d partial, %0d inside; %0d mismatches",
             n_outside, n_partial, n_inside, err_count);
    if (err_count == 0) begin
      $display("frustum_sphere_box_cull test passed");
    end else begin
      $display("frustum_sphere_box_cull test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/fsbc_pkg.sv
design/fsbc_mul.sv
design/fsbc_judge.sv
design/frustum_sphere_box_cull.sv
test/frustum_sphere_box_cull_tb.sv
